// ===== rtl/gf2_pkg.sv =====
// shared types and constants for the gf2 polynomial alu
package gf2_pkg;

	localparam int unsigned POLY_WIDTH_DEF = 32;
	localparam int unsigned OPW = 32;
	localparam int unsigned MAINW = 63;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_MUL = 2'd1;
	localparam logic [1:0] OP_DIV = 2'd2;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [OPW-1:0]   operand_a;
		logic [OPW-1:0]   operand_b;
	} gf2_in_t;

	typedef struct packed {
		logic [MAINW-1:0] main_result;
		logic [OPW-1:0]   remainder;
		logic             divide_by_zero;
	} gf2_out_t;

endpackage

// ===== rtl/gf2_polynomial_alu.sv =====
// top level of the gf2 polynomial alu: add, carry-less multiply, divide
//
// channel | handshake        | payload
// in      | start, busy      | in_beat  (gf2_pkg::gf2_in_t)
// out     | done strobe      | out_beat (gf2_pkg::gf2_out_t)
//
// a beat enters every cycle; it passes through the chain of stages, each
// retiring four product bits and four quotient bits, and then through
// the output register
// busy is never raised; the receiver cannot stall, so nothing holds
// reset clears only the valid bits of the stages and the done strobe
module gf2_polynomial_alu #(
	parameter int unsigned POLY_WIDTH = gf2_pkg::POLY_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  gf2_pkg::gf2_in_t  in_beat,
	output logic              done,
	output gf2_pkg::gf2_out_t out_beat
);
	localparam int unsigned PW = POLY_WIDTH;
	localparam int unsigned SW = 2*PW-1;
	localparam int unsigned NS = (PW+3)/4;

	logic          v   [NS+1];
	logic [1:0]    op  [NS+1];
	logic [PW-1:0] a   [NS+1];
	logic [PW-1:0] b   [NS+1];
	logic [SW-1:0] acc [NS+1];
	logic [PW-1:0] q   [NS+1];
	logic [PW-1:0] r   [NS+1];

	// pipeline entry, operands trimmed to the polynomial width
	assign busy  = 1'b0;
	assign v[0]  = start;
	assign op[0] = in_beat.opcode;
	assign a[0]  = in_beat.operand_a[PW-1:0];
	assign b[0]  = in_beat.operand_b[PW-1:0];
	assign acc[0] = '0;
	assign q[0]  = '0;
	assign r[0]  = in_beat.operand_a[PW-1:0];

	for (genvar g = 0; g < NS; g++) begin : g_st
		gf2_stage #(.POLY_WIDTH(PW), .BASE(4*g)) u_st (
			.clk(clk), .arst_n(arst_n),
			.vin(v[g]), .op_in(op[g]), .a_in(a[g]), .b_in(b[g]),
			.acc_in(acc[g]), .q_in(q[g]), .r_in(r[g]),
			.vout(v[g+1]), .op_out(op[g+1]), .a_out(a[g+1]), .b_out(b[g+1]),
			.acc_out(acc[g+1]), .q_out(q[g+1]), .r_out(r[g+1])
		);
	end

	// result selection by opcode
	gf2_pkg::gf2_out_t res_n;
	always_comb begin
		res_n = '0;
		unique case (op[NS])
			gf2_pkg::OP_ADD: res_n.main_result =
				gf2_pkg::MAINW'(a[NS] ^ b[NS]);
			gf2_pkg::OP_MUL: res_n.main_result = gf2_pkg::MAINW'(acc[NS]);
			gf2_pkg::OP_DIV: begin
				if (b[NS] == '0) begin
					res_n.main_result = gf2_pkg::MAINW'(a[NS]);
					res_n.divide_by_zero = 1'b1;
				end else begin
					res_n.main_result = gf2_pkg::MAINW'(q[NS]);
					res_n.remainder = gf2_pkg::OPW'(r[NS]);
				end
			end
			default: res_n = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= v[NS];
	end

	always_ff @(posedge clk) begin
		out_beat <= res_n;
	end

	// done is registered from the valid bit of the last stage, so no result beat is lost
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		v[NS] |=> done) else $error("lost result beat");
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_beat.divide_by_zero |-> out_beat.remainder == '0)
		else $error("remainder with zero divisor");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy raised");

endmodule

// ===== rtl/gf2_stage.sv =====
// one pipeline stage: four multiply bits and four division steps
module gf2_stage #(
	parameter int unsigned POLY_WIDTH = gf2_pkg::POLY_WIDTH_DEF,
	parameter int unsigned BASE = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     vin,
	input  logic [1:0]               op_in,
	input  logic [POLY_WIDTH-1:0]    a_in,
	input  logic [POLY_WIDTH-1:0]    b_in,
	input  logic [2*POLY_WIDTH-2:0]  acc_in,
	input  logic [POLY_WIDTH-1:0]    q_in,
	input  logic [POLY_WIDTH-1:0]    r_in,
	output logic                     vout,
	output logic [1:0]               op_out,
	output logic [POLY_WIDTH-1:0]    a_out,
	output logic [POLY_WIDTH-1:0]    b_out,
	output logic [2*POLY_WIDTH-2:0]  acc_out,
	output logic [POLY_WIDTH-1:0]    q_out,
	output logic [POLY_WIDTH-1:0]    r_out
);
	localparam int unsigned PW = POLY_WIDTH;
	localparam int unsigned SW = 2*PW-1;
	localparam int unsigned DW = $clog2(PW+1);

	logic [SW-1:0] acc_n;
	logic [PW-1:0] q_n, r_n;
	logic [DW-1:0] db;
	logic          bnz;

	// degree of the divisor, plain priority scan
	always_comb begin
		db = '0;
		bnz = 1'b0;
		for (int k = 0; k < PW; k++) begin
			if (b_in[k]) begin
				db = DW'(k);
				bnz = 1'b1;
			end
		end
	end

	always_comb begin
		int i;
		acc_n = acc_in;
		q_n = q_in;
		r_n = r_in;
		for (int s = 0; s < 4; s++) begin
			if (BASE + s < PW) begin
				if (b_in[BASE+s])
					acc_n = acc_n ^ (SW'(a_in) << (BASE+s));
				i = PW - 1 - (BASE + s);
				if (bnz && (i >= int'(db)) && r_n[i]) begin
					q_n = q_n | (PW'(1) << (i - int'(db)));
					r_n = r_n ^ (b_in << (i - int'(db)));
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vout <= 1'b0;
		else
			vout <= vin;
	end

	always_ff @(posedge clk) begin
		op_out  <= op_in;
		a_out   <= a_in;
		b_out   <= b_in;
		acc_out <= acc_n;
		q_out   <= q_n;
		r_out   <= r_n;
	end

endmodule
